[rtl/bounded_int_binarizer_core_macros.svh]
// ----------------------------------------------------------------------------
// bounded_int_binarizer_core_macros
// assertion helpers shared by the binarizer rtl, clocked on clk, held off in rst
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INT_BINARIZER_CORE_MACROS_SVH
`define BOUNDED_INT_BINARIZER_CORE_MACROS_SVH

// same-cycle implication
`define BIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bib_pkg.sv]
// ----------------------------------------------------------------------------
// bib_pkg
// shared widths and context group codes of the bounded integer binarizer
// ----------------------------------------------------------------------------
`default_nettype none

package bib_pkg;

  localparam int FIELD_W  = 17;               // input field width, two's complement
  localparam int MAG_BITS = 16;               // magnitude bits of a legal field
  localparam int POS_W    = $clog2(MAG_BITS); // bit position within a magnitude
  localparam int IDX_W    = 4;                // ctx_index width
  localparam int KIND_W   = 2;                // ctx_kind width

  typedef enum logic [KIND_W-1:0] {
    KIND_ZERO = 2'd0,
    KIND_EXP  = 2'd1,
    KIND_SIGN = 2'd2,
    KIND_MANT = 2'd3
  } ctx_kind_t;

endpackage

`default_nettype wire

[rtl/bounded_int_binarizer_core.sv]
// ----------------------------------------------------------------------------
// bounded_int_binarizer_core
// zero / exponent / sign / mantissa binarization of a bounded signed value
// ----------------------------------------------------------------------------
// One transaction on the item channel carries value, range_low and range_high;
// the block answers with the ordered decisions of the binarization on the
// decision channel, one decision per transaction, the final one marked by
// last. An item whose bounds are broken (range_low >= range_high, value out of
// range) or whose magnitudes exceed MAG_BITS bits yields no decisions. After
// the accepting edge the block checks the bounds and forms the magnitudes
// (ST_CHECK, ST_RANGE), runs a bit-serial scan over the MAG_BITS magnitude
// bits that finds the exponents and the comparison state of the mantissa,
// plans (ST_PLAN), and then issues one decision per cycle (1 to 32 per item)
// while the consumer keeps dec_ready high; a dropped item leaves from ST_RANGE.
// Item time is set by the msb-first scan and by the single decision port. A
// new item is accepted as soon as the last decision sits in the output
// register, even if it has not been taken yet.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_int_binarizer_core_macros.svh"

module bounded_int_binarizer_core
  import bib_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // item channel
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic signed [FIELD_W-1:0] value,
  input  logic signed [FIELD_W-1:0] range_low,
  input  logic signed [FIELD_W-1:0] range_high,
  // decision channel
  output logic                      dec_valid,
  input  logic                      dec_ready,
  output logic [KIND_W-1:0]         ctx_kind,
  output logic [IDX_W-1:0]          ctx_index,
  output logic                      bin,
  output logic                      coded,
  output logic                      last
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_CHECK = 10'b00_0000_0010,
    ST_RANGE = 10'b00_0000_0100,
    ST_SCAN  = 10'b00_0000_1000,
    ST_PLAN  = 10'b00_0001_0000,
    ST_ZERO  = 10'b00_0010_0000,
    ST_EXP   = 10'b00_0100_0000,
    ST_STOP  = 10'b00_1000_0000,
    ST_SIGN  = 10'b01_0000_0000,
    ST_MANT  = 10'b10_0000_0000
  } state_t;

  // relation of the running prefix to a bound: {greater, less}, zero is equal
  localparam logic [1:0] REL_EQ = 2'b00;

  function automatic logic [1:0] rel_step(input logic [1:0] rel, input logic rb,
                                          input logic mb);
    logic [1:0] res;
    res = rel;
    if (rel == REL_EQ) begin
      res = {rb & ~mb, ~rb & mb};
    end
    return res;
  endfunction

  // control
  state_t             state, state_next;
  logic [POS_W-1:0]   cnt, cnt_next;

  // captured item
  logic signed [FIELD_W-1:0] val_r, lo_r, hi_r;
  logic signed [FIELD_W-1:0] val_r_next, lo_r_next, hi_r_next;

  // check stage results
  logic               ord_ok, ord_ok_next;
  logic [FIELD_W-1:0] a_mag, hi_mag, lo_mag;
  logic [FIELD_W-1:0] a_mag_next, hi_mag_next, lo_mag_next;

  // range stage results
  logic               both_r, both_r_next;
  logic               amin_zero, amin_zero_next;
  logic               a_zero, a_zero_next;
  logic               neg_r, neg_r_next;

  // bit-serial shifters: log search and mantissa walk
  logic [MAG_BITS-1:0] max_sh, min_sh, a_sh, mx_sh, mn_sh;
  logic [MAG_BITS-1:0] max_sh_next, min_sh_next, a_sh_next, mx_sh_next, mn_sh_next;

  logic               max_found, min_found, e_found;
  logic               max_found_next, min_found_next, e_found_next;
  logic [POS_W-1:0]   bmax, bmin, e_pos;
  logic [POS_W-1:0]   bmax_next, bmin_next, e_pos_next;
  logic [1:0]         rmx, rmn, rmx_next, rmn_next;

  // output register
  logic               dec_valid_next;
  logic [KIND_W-1:0]  ctx_kind_next;
  logic [IDX_W-1:0]   ctx_index_next;
  logic               bin_next, coded_next, last_next;

  // combinational helpers
  logic               emit_ok;
  logic               oversized, zero_in, both_c, val_pos;
  logic [FIELD_W-1:0] amax_c, amin_c, mymax_c;
  logic               m_over, m_under, m_bit, m_coded;
  state_t             nx_mant, nx_sign, nx_stop, nx_exp;

  assign item_ready = (state == ST_IDLE);
  assign emit_ok    = ~dec_valid | dec_ready;

  // range stage: bound magnitudes and the limit of the value's own sign side
  assign oversized = (|(a_mag >> MAG_BITS)) | (|(hi_mag >> MAG_BITS))
                   | (|(lo_mag >> MAG_BITS));
  assign zero_in   = ~hi_r[FIELD_W-1] & (lo_r[FIELD_W-1] | (lo_r == '0));
  assign both_c    = lo_r[FIELD_W-1] & ~hi_r[FIELD_W-1] & (hi_r != '0);
  assign val_pos   = ~val_r[FIELD_W-1] & (val_r != '0);
  assign amax_c    = (hi_mag > lo_mag) ? hi_mag : lo_mag;
  assign amin_c    = zero_in ? '0 : ((hi_mag < lo_mag) ? hi_mag : lo_mag);
  assign mymax_c   = both_c ? (val_pos ? hi_mag : lo_mag) : amax_c;

  // mantissa bit: forced low when it would pass the limit, forced high when
  // all-ones below could not reach the smaller bound
  assign m_over  = rmx[1] | ((rmx == REL_EQ) & ~mx_sh[MAG_BITS-1]);
  assign m_under = rmn[0] | ((rmn == REL_EQ) & mn_sh[MAG_BITS-1]);
  assign m_bit   = m_over ? 1'b0 : (m_under ? 1'b1 : a_sh[MAG_BITS-1]);
  assign m_coded = ~m_over & ~m_under;

  // what follows each group of decisions
  assign nx_mant = (e_pos != '0) ? ST_MANT : ST_IDLE;
  assign nx_sign = both_r ? ST_SIGN : nx_mant;
  assign nx_stop = (e_pos < bmax) ? ST_STOP : nx_sign;
  assign nx_exp  = (bmin < e_pos) ? ST_EXP : nx_stop;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    val_r_next     = val_r;
    lo_r_next      = lo_r;
    hi_r_next      = hi_r;
    ord_ok_next    = ord_ok;
    a_mag_next     = a_mag;
    hi_mag_next    = hi_mag;
    lo_mag_next    = lo_mag;
    both_r_next    = both_r;
    amin_zero_next = amin_zero;
    a_zero_next    = a_zero;
    neg_r_next     = neg_r;
    max_sh_next    = max_sh;
    min_sh_next    = min_sh;
    a_sh_next      = a_sh;
    mx_sh_next     = mx_sh;
    mn_sh_next     = mn_sh;
    max_found_next = max_found;
    min_found_next = min_found;
    e_found_next   = e_found;
    bmax_next      = bmax;
    bmin_next      = bmin;
    e_pos_next     = e_pos;
    rmx_next       = rmx;
    rmn_next       = rmn;
    dec_valid_next = dec_valid & ~dec_ready;
    ctx_kind_next  = ctx_kind;
    ctx_index_next = ctx_index;
    bin_next       = bin;
    coded_next     = coded;
    last_next      = last;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          val_r_next = value;
          lo_r_next  = range_low;
          hi_r_next  = range_high;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        ord_ok_next = (lo_r < hi_r) & (val_r >= lo_r) & (val_r <= hi_r);
        a_mag_next  = val_r[FIELD_W-1] ? FIELD_W'(-val_r) : FIELD_W'(val_r);
        hi_mag_next = hi_r[FIELD_W-1]  ? FIELD_W'(-hi_r)  : FIELD_W'(hi_r);
        lo_mag_next = lo_r[FIELD_W-1]  ? FIELD_W'(-lo_r)  : FIELD_W'(lo_r);
        state_next  = ST_RANGE;
      end

      ST_RANGE: begin
        both_r_next    = both_c;
        amin_zero_next = zero_in;
        a_zero_next    = (val_r == '0);
        neg_r_next     = val_r[FIELD_W-1];
        max_sh_next    = MAG_BITS'(amax_c);
        min_sh_next    = MAG_BITS'(amin_c);
        a_sh_next      = MAG_BITS'(a_mag);
        mx_sh_next     = MAG_BITS'(mymax_c);
        mn_sh_next     = MAG_BITS'(amin_c);
        max_found_next = 1'b0;
        min_found_next = 1'b0;
        e_found_next   = 1'b0;
        bmax_next      = '0;
        bmin_next      = '0;
        e_pos_next     = '0;
        rmx_next       = REL_EQ;
        rmn_next       = REL_EQ;
        cnt_next       = POS_W'(MAG_BITS - 1);
        state_next     = (ord_ok & ~oversized) ? ST_SCAN : ST_IDLE;
      end

      ST_SCAN: begin
        // msb-first: top set bit of each magnitude
        max_sh_next = max_sh << 1;
        min_sh_next = min_sh << 1;
        if (max_sh[MAG_BITS-1] && !max_found) begin
          max_found_next = 1'b1;
          bmax_next      = cnt;
        end
        if (min_sh[MAG_BITS-1] && !min_found) begin
          min_found_next = 1'b1;
          bmin_next      = cnt;
        end
        // mantissa walk runs down to the exponent bit and parks below it
        if (!e_found) begin
          rmx_next   = rel_step(rmx, a_sh[MAG_BITS-1], mx_sh[MAG_BITS-1]);
          rmn_next   = rel_step(rmn, a_sh[MAG_BITS-1], mn_sh[MAG_BITS-1]);
          a_sh_next  = a_sh << 1;
          mx_sh_next = mx_sh << 1;
          mn_sh_next = mn_sh << 1;
          if (a_sh[MAG_BITS-1]) begin
            e_found_next = 1'b1;
            e_pos_next   = cnt;
          end
        end
        if (cnt == '0) begin
          state_next = ST_PLAN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end

      ST_PLAN: begin
        state_next = (a_zero || amin_zero) ? ST_ZERO : nx_exp;
      end

      ST_ZERO: begin
        if (emit_ok) begin
          state_next     = a_zero ? ST_IDLE : nx_exp;
          dec_valid_next = 1'b1;
          ctx_kind_next  = KIND_ZERO;
          ctx_index_next = '0;
          bin_next       = a_zero;
          coded_next     = 1'b1;
        end
      end

      ST_EXP: begin
        if (emit_ok) begin
          state_next     = (({1'b0, cnt} + 1'b1) < {1'b0, e_pos}) ? ST_EXP : nx_stop;
          cnt_next       = cnt + 1'b1;
          dec_valid_next = 1'b1;
          ctx_kind_next  = KIND_EXP;
          ctx_index_next = IDX_W'(cnt);
          bin_next       = 1'b1;
          coded_next     = 1'b1;
        end
      end

      ST_STOP: begin
        if (emit_ok) begin
          state_next     = nx_sign;
          dec_valid_next = 1'b1;
          ctx_kind_next  = KIND_EXP;
          ctx_index_next = IDX_W'(e_pos);
          bin_next       = 1'b0;
          coded_next     = 1'b1;
        end
      end

      ST_SIGN: begin
        if (emit_ok) begin
          state_next     = nx_mant;
          dec_valid_next = 1'b1;
          ctx_kind_next  = KIND_SIGN;
          ctx_index_next = IDX_W'(e_pos);
          bin_next       = neg_r;
          coded_next     = 1'b1;
        end
      end

      ST_MANT: begin
        if (emit_ok) begin
          state_next     = (cnt == '0) ? ST_IDLE : ST_MANT;
          cnt_next       = cnt - 1'b1;
          rmx_next       = rel_step(rmx, m_bit, mx_sh[MAG_BITS-1]);
          rmn_next       = rel_step(rmn, m_bit, mn_sh[MAG_BITS-1]);
          a_sh_next      = a_sh << 1;
          mx_sh_next     = mx_sh << 1;
          mn_sh_next     = mn_sh << 1;
          dec_valid_next = 1'b1;
          ctx_kind_next  = KIND_MANT;
          ctx_index_next = IDX_W'(cnt);
          bin_next       = m_bit;
          coded_next     = m_coded;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // counter load on entry to a counted group
    if (state_next != state) begin
      if (state_next == ST_EXP) begin
        cnt_next = bmin;
      end else if (state_next == ST_MANT) begin
        cnt_next = e_pos - 1'b1;
      end
    end

    // a decision is final when nothing follows it
    if (dec_valid_next && emit_ok && (state != ST_IDLE) && (state != ST_CHECK)
        && (state != ST_RANGE) && (state != ST_SCAN) && (state != ST_PLAN)) begin
      last_next = (state_next == ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      dec_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      dec_valid <= dec_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_r_next;
    lo_r      <= lo_r_next;
    hi_r      <= hi_r_next;
    ord_ok    <= ord_ok_next;
    a_mag     <= a_mag_next;
    hi_mag    <= hi_mag_next;
    lo_mag    <= lo_mag_next;
    both_r    <= both_r_next;
    amin_zero <= amin_zero_next;
    a_zero    <= a_zero_next;
    neg_r     <= neg_r_next;
    max_sh    <= max_sh_next;
    min_sh    <= min_sh_next;
    a_sh      <= a_sh_next;
    mx_sh     <= mx_sh_next;
    mn_sh     <= mn_sh_next;
    max_found <= max_found_next;
    min_found <= min_found_next;
    e_found   <= e_found_next;
    bmax      <= bmax_next;
    bmin      <= bmin_next;
    e_pos     <= e_pos_next;
    rmx       <= rmx_next;
    rmn       <= rmn_next;
    ctx_kind  <= ctx_kind_next;
    ctx_index <= ctx_index_next;
    bin       <= bin_next;
    coded     <= coded_next;
    last      <= last_next;
  end

  // exponent of the value lies between those of the bounds
  `BIB_ASSERT_NOW(a_exp_order, (state == ST_PLAN) && !a_zero, (bmin <= e_pos) && (e_pos <= bmax), "value exponent outside bound exponents")
  // counted groups stay below the value exponent
  `BIB_ASSERT_NOW(a_cnt_bound, (state == ST_EXP) || (state == ST_MANT), cnt < e_pos, "group counter passed the exponent")
  // a mantissa emission is final exactly at bit zero
  `BIB_ASSERT_NEXT(a_mant_last, (state == ST_MANT) && emit_ok, dec_valid && (ctx_kind == KIND_MANT) && (last == (ctx_index == '0)), "mantissa last flag misplaced")
  // only mantissa bits can be model-update only
  `BIB_ASSERT_NOW(a_uncoded_kind, dec_valid && !coded, ctx_kind == KIND_MANT, "uncoded decision outside mantissa")

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for bounded_int_binarizer_core: a table of directed
// items, then random bounded and broken values, with every decision compared in order
// against a behavioral predictor under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bib_pkg::*;

  localparam int MAG_LIMIT    = (1 << MAG_BITS) - 1;
  localparam int RANDOM_ITEMS = 130;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 64;    // one full item time with margin
  localparam int REPORT_MAX   = 10;

  // how a table row gets its expected decisions
  typedef enum int {
    OUTCOME_NONE,   // dropped item, nothing comes out
    OUTCOME_ZERO,   // value zero inside the range, a lone zero flag
    OUTCOME_MODEL   // worked out by the predictor
  } outcome_t;

  // receiver behavior, switched after stretches of random length
  typedef enum int {
    FLOW_OPEN,
    FLOW_CHOPPY,
    FLOW_STARVED
  } flow_t;

  typedef struct {
    ctx_kind_t  kind;
    logic [3:0] idx;
    logic       bin;
    logic       coded;
    logic       last;
  } decision_t;

  typedef struct {
    int       v;
    int       lo;
    int       hi;
    outcome_t how;
  } stim_row_t;

  // directed items: empty and broken ranges, oversized fields, zero, extremes,
  // one-sided ranges, narrow windows and ranges that straddle zero
  stim_row_t directed_rows [23] = '{
    '{0,       -1,      1,      OUTCOME_ZERO},
    '{0,       0,       65535,  OUTCOME_ZERO},
    '{0,       -65535,  0,      OUTCOME_ZERO},
    '{5,       5,       5,      OUTCOME_NONE},   // empty range
    '{3,       10,      2,      OUTCOME_NONE},   // bounds swapped
    '{-5,      -4,      4,      OUTCOME_NONE},   // below the range
    '{9,       -4,      8,      OUTCOME_NONE},   // above the range
    '{-65536,  -65536,  0,      OUTCOME_NONE},   // magnitude too large
    '{0,       -65536,  5,      OUTCOME_NONE},   // low bound too large
    '{65535,   -65535,  65535,  OUTCOME_MODEL},
    '{-65535,  -65535,  65535,  OUTCOME_MODEL},
    '{1,       0,       1,      OUTCOME_MODEL},
    '{-1,      -1,      0,      OUTCOME_MODEL},
    '{65535,   1,       65535,  OUTCOME_MODEL},
    '{-65535,  -65535,  -1,     OUTCOME_MODEL},
    '{100,     64,      127,    OUTCOME_MODEL},
    '{-100,    -127,    -64,    OUTCOME_MODEL},
    '{37,      -40,     50,     OUTCOME_MODEL},
    '{-3000,   -3000,   200,    OUTCOME_MODEL},
    '{32768,   32768,   65535,  OUTCOME_MODEL},
    '{5,       4,       6,      OUTCOME_MODEL},
    '{-65535,  -65535,  -65534, OUTCOME_MODEL},
    '{-7,      -9,      1000,   OUTCOME_MODEL}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      item_valid = 1'b0;
  logic                      item_ready;
  logic signed [FIELD_W-1:0] value      = '0;
  logic signed [FIELD_W-1:0] range_low  = '0;
  logic signed [FIELD_W-1:0] range_high = '0;

  logic              dec_valid;
  logic              dec_ready = 1'b0;
  logic [KIND_W-1:0] ctx_kind;
  logic [IDX_W-1:0]  ctx_index;
  logic              bin;
  logic              coded;
  logic              last;

  decision_t expected_decisions[$];
  decision_t oldest_decision;
  int        mismatch_count = 0;
  int        burst_left     = 0;
  int        idle_cycles    = 0;
  flow_t     flow_mode      = FLOW_OPEN;
  int        flow_left      = 0;

  bounded_int_binarizer_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .value      (value),
    .range_low  (range_low),
    .range_high (range_high),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .ctx_kind   (ctx_kind),
    .ctx_index  (ctx_index),
    .bin        (bin),
    .coded      (coded),
    .last       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int magnitude(input int x);
    return (x < 0) ? -x : x;
  endfunction

  // floor(log2), with zero mapped to zero
  function automatic int msb_index(input int x);
    int r;
    r = 0;
    while (x > 1) begin
      x = x >> 1;
      r++;
    end
    return r;
  endfunction

  // appends the decision sequence of one item to expected_decisions
  function automatic void predict_decisions(input int v, input int lo, input int hi);
    int   alo, ahi, amax, amin, side_max, e_top, e_floor, e, run, rest, w, i, av;
    bit   straddle;
    logic b, c;
    if (lo >= hi || v < lo || v > hi)
      return;
    if (magnitude(v) > MAG_LIMIT || magnitude(lo) > MAG_LIMIT || magnitude(hi) > MAG_LIMIT)
      return;
    alo      = magnitude(lo);
    ahi      = magnitude(hi);
    amax     = (ahi > alo) ? ahi : alo;
    amin     = (hi >= 0 && lo <= 0) ? 0 : ((ahi < alo) ? ahi : alo);
    straddle = (lo < 0 && hi > 0);
    // with both signs allowed, the mantissa is bounded by the bound on its own side
    side_max = straddle ? ((v > 0) ? ahi : alo) : amax;
    e_top    = msb_index(amax);
    e_floor  = msb_index(amin);
    if (v == 0) begin
      expected_decisions.push_back('{KIND_ZERO, 4'd0, 1'b1, 1'b1, 1'b0});
    end else begin
      av = magnitude(v);
      e  = msb_index(av);
      if (amin == 0)
        expected_decisions.push_back('{KIND_ZERO, 4'd0, 1'b0, 1'b1, 1'b0});
      // unary exponent from the floor, the stop bit left out at the top
      for (i = e_floor; i < e; i++)
        expected_decisions.push_back('{KIND_EXP, 4'(i), 1'b1, 1'b1, 1'b0});
      if (e < e_top)
        expected_decisions.push_back('{KIND_EXP, 4'(i), 1'b0, 1'b1, 1'b0});
      if (straddle)
        expected_decisions.push_back('{KIND_SIGN, 4'(e), logic'(v < 0), 1'b1, 1'b0});
      // mantissa msb first, bits that the bounds force are update-only
      run  = 1 << e;
      rest = run - 1;
      for (i = e - 1; i >= 0; i--) begin
        w    = 1 << i;
        rest = rest ^ w;
        if (run + w > side_max) begin
          b = 1'b0;
          c = 1'b0;
        end else if (run + rest < amin) begin
          b = 1'b1;
          c = 1'b0;
        end else begin
          b = av[i];
          c = 1'b1;
        end
        expected_decisions.push_back('{KIND_MANT, 4'(i), b, c, 1'b0});
        if (b)
          run = run | w;
      end
    end
    expected_decisions[$].last = 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s", msg);
  endtask

  // one item transaction, sender bursts separated by random gaps
  task automatic send_item(input int v, input int lo, input int hi, input outcome_t how);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    item_valid <= 1'b1;
    value      <= FIELD_W'(v);
    range_low  <= FIELD_W'(lo);
    range_high <= FIELD_W'(hi);
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left--;
    // the payload regs still hold this transaction here
    case (how)
      OUTCOME_ZERO:  expected_decisions.push_back('{KIND_ZERO, 4'd0, 1'b1, 1'b1, 1'b1});
      OUTCOME_MODEL: predict_decisions(int'(value), int'(range_low), int'(range_high));
      default: ;
    endcase
  endtask

  // well-formed item: ordered distinct bounds at a random scale, value inside
  function automatic void pick_bounded_item(output int v, output int lo, output int hi);
    int span, a, b, shape, pick;
    span  = (1 << $urandom_range(1, MAG_BITS)) - 1;
    shape = $urandom_range(0, 3);
    a     = -span + int'($urandom_range(0, 2 * span));
    b     = -span + int'($urandom_range(0, 2 * span));
    case (shape)
      1: begin
        a = magnitude(a);
        b = magnitude(b);
      end
      2: begin
        a = -magnitude(a);
        b = -magnitude(b);
      end
      3: begin
        // narrow window, most mantissa bits forced
        if (a == span)
          a = span - 1;
        b = a + $urandom_range(1, (span - a < 8) ? span - a : 8);
      end
      default: ;
    endcase
    if (a == b)
      b = (a < span) ? a + 1 : a - 1;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       v = lo;
      1:       v = hi;
      2:       v = (lo <= 0 && hi >= 0) ? 0 : lo;
      default: v = lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  // noise: raw fields, swapped bounds, a value just outside, an empty range
  function automatic void pick_broken_item(output int v, output int lo, output int hi);
    int a, b, c;
    pick_bounded_item(a, b, c);
    case ($urandom_range(0, 3))
      0: begin
        v  = int'($urandom_range(0, (1 << FIELD_W) - 1));
        lo = int'($urandom_range(0, (1 << FIELD_W) - 1));
        hi = int'($urandom_range(0, (1 << FIELD_W) - 1));
      end
      1: begin
        v  = a;
        lo = c;
        hi = b;
      end
      2: begin
        v  = ($urandom_range(0, 1) == 1) ? c + 1 : b - 1;
        lo = b;
        hi = c;
      end
      default: begin
        v  = a;
        lo = a;
        hi = a;
      end
    endcase
  endfunction

  // stimulus
  initial begin
    int v, lo, hi, good_items;
    good_items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[r])
      send_item(directed_rows[r].v, directed_rows[r].lo, directed_rows[r].hi,
                directed_rows[r].how);
    // random part, noise items do not count
    while (good_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        pick_broken_item(v, lo, hi);
      end else begin
        pick_bounded_item(v, lo, hi);
        good_items++;
      end
      send_item(v, lo, hi, OUTCOME_MODEL);
    end
    item_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    // catch any decision that trails the expected ones
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_decisions.size() != 0)
      log_mismatch($sformatf("%0d expected decisions never arrived",
                             expected_decisions.size()));
    if (mismatch_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // receiver: open, choppy and starved stretches of random length
  always @(posedge clk) begin
    if (rst) begin
      dec_ready <= 1'b0;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(0, 2));
        flow_left = $urandom_range(4, 40);
      end else begin
        flow_left--;
      end
      case (flow_mode)
        FLOW_OPEN:   dec_ready <= 1'b1;
        FLOW_CHOPPY: dec_ready <= 1'($urandom_range(0, 1));
        default:     dec_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // decision checker, in order against the oldest expectation
  always @(posedge clk) begin
    if (!rst && dec_valid && dec_ready) begin
      if (expected_decisions.size() == 0) begin
        log_mismatch($sformatf(
          "unexpected decision kind=%0d idx=%0d bin=%0b coded=%0b last=%0b",
          ctx_kind, ctx_index, bin, coded, last));
      end else begin
        oldest_decision = expected_decisions.pop_front();
        if (ctx_kind !== oldest_decision.kind || ctx_index !== oldest_decision.idx ||
            bin !== oldest_decision.bin || coded !== oldest_decision.coded ||
            last !== oldest_decision.last)
          log_mismatch({
            $sformatf("decision mismatch: expected kind=%0d idx=%0d bin=%0b coded=%0b",
                      oldest_decision.kind, oldest_decision.idx, oldest_decision.bin,
                      oldest_decision.coded),
            $sformatf(" last=%0b, got kind=%0d idx=%0d bin=%0b coded=%0b last=%0b",
                      oldest_decision.last, ctx_kind, ctx_index, bin, coded, last)});
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (dec_valid && dec_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
